/* hdl/assert_macros.svh */
// Assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge outside reset
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLK(label, !(cond), msg)

`endif

/* hdl/bftr_pkg.sv */
package bftr_pkg;

  // Default sizes
  localparam int FontBytesDef    = 8192;  // power of two, 256..65536
  localparam int MaxGlyphRowsDef = 32;    // 1..64

  // Register indexes
  typedef enum logic [2:0] {
    CFG_FRAME_BASE   = 3'd0,
    CFG_LINE_PITCH   = 3'd1,
    CFG_GLYPH_WIDTH  = 3'd2,
    CFG_GLYPH_HEIGHT = 3'd3,
    CFG_GLYPH_COUNT  = 3'd4,
    CFG_GLYPH_BYTES  = 3'd5,
    CFG_HEADER_BYTES = 3'd6
  } cfg_index_e;

  // Register reset values
  localparam logic [31:0] FrameBaseRst   = 32'd0;
  localparam logic [15:0] LinePitchRst   = 16'd4096;
  localparam logic [3:0]  GlyphWidthRst  = 4'd8;
  localparam logic [5:0]  GlyphHeightRst = 6'd16;
  localparam logic [9:0]  GlyphCountRst  = 10'd256;
  localparam logic [8:0]  GlyphBytesRst  = 9'd16;
  localparam logic [7:0]  HeaderBytesRst = 8'd32;

  // Item kinds and control characters
  localparam logic       KindLoad = 1'b0;
  localparam logic       KindChar = 1'b1;
  localparam logic [7:0] ChCr     = 8'd13;
  localparam logic [7:0] ChLf     = 8'd10;
  localparam logic [3:0] MaxWidth = 4'd8;

  // Input tdata layout
  localparam int InDataW = 64;
  localparam int OutDataW = 40;

  typedef struct packed {
    logic [1:0]  pad;
    logic [15:0] start_y;
    logic [15:0] start_x;
    logic        start_req;
    logic [7:0]  ch;
    logic [7:0]  font_byte;
    logic [12:0] font_addr;
  } in_data_t;

  typedef struct packed {
    logic [7:0]  row_bits;
    logic [31:0] row_address;
  } out_data_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_ADDR = 4'b0100,
    ST_ROWS = 4'b1000
  } state_e;

endpackage

/* hdl/bitmap_font_text_renderer.sv */
// A drawn character is taken only in idle: its glyph index is registered,
// ST_MUL forms the products, ST_ADDR the addresses, then one font store read
// per row on the single read port; loads, CR and LF are taken without leaving idle.
// Output words are buffered, so rows keep flowing while the sink accepts.
// Reset (rst_ni low, async) clears cursor, registers and handshake state;
// the font store is not cleared and holds garbage until loaded.
module bitmap_font_text_renderer #(
  parameter int FONT_BYTES     = bftr_pkg::FontBytesDef,
  parameter int MAX_GLYPH_ROWS = bftr_pkg::MaxGlyphRowsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: font_addr[12:0], font_byte[20:13], ch[28:21], start_req[29],
  //        start_x[45:30], start_y[61:46], zero[63:62]
  input  logic [bftr_pkg::InDataW-1:0] s_axis_tdata,
  // tuser: kind[0]
  input  logic        s_axis_tuser,
  // output words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: row_address[31:0], row_bits[39:32]
  output logic [bftr_pkg::OutDataW-1:0] m_axis_tdata,
  output logic        m_axis_tlast,
  // register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int AW  = $clog2(FONT_BYTES);
  localparam int FAW = (AW > 13) ? AW : 13;
  localparam int RW  = $clog2(MAX_GLYPH_ROWS + 1);

  // Configuration registers
  logic [31:0] frame_base_q;
  logic [15:0] line_pitch_q;
  logic [3:0]  glyph_width_q;
  logic [5:0]  glyph_height_q;
  logic [9:0]  glyph_count_q;
  logic [8:0]  glyph_bytes_q;
  logic [7:0]  header_bytes_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_base_q   <= bftr_pkg::FrameBaseRst;
      line_pitch_q   <= bftr_pkg::LinePitchRst;
      glyph_width_q  <= bftr_pkg::GlyphWidthRst;
      glyph_height_q <= bftr_pkg::GlyphHeightRst;
      glyph_count_q  <= bftr_pkg::GlyphCountRst;
      glyph_bytes_q  <= bftr_pkg::GlyphBytesRst;
      header_bytes_q <= bftr_pkg::HeaderBytesRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bftr_pkg::CFG_FRAME_BASE:   frame_base_q   <= cfg_data_i;
        bftr_pkg::CFG_LINE_PITCH:   line_pitch_q   <= cfg_data_i[15:0];
        bftr_pkg::CFG_GLYPH_WIDTH:  glyph_width_q  <= cfg_data_i[3:0];
        bftr_pkg::CFG_GLYPH_HEIGHT: glyph_height_q <= cfg_data_i[5:0];
        bftr_pkg::CFG_GLYPH_COUNT:  glyph_count_q  <= cfg_data_i[9:0];
        bftr_pkg::CFG_GLYPH_BYTES:  glyph_bytes_q  <= cfg_data_i[8:0];
        bftr_pkg::CFG_HEADER_BYTES: header_bytes_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Input decode
  bftr_pkg::in_data_t in_w;
  assign in_w = bftr_pkg::in_data_t'(s_axis_tdata);

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  logic [FAW-1:0] load_addr_ext;
  assign load_addr_ext = FAW'(in_w.font_addr);

  // Sequencer and datapath state
  bftr_pkg::state_e state_q, state_d;
  logic [15:0] cursor_x_q, cursor_y_q;
  logic [7:0]  gidx_q;
  logic [31:0] prod_y_q;
  logic [16:0] prod_g_q;
  logic [AW-1:0] ptr_q;
  logic [31:0] row_addr_q;
  logic [RW-1:0] rows_q, row_cnt_q;

  // Cursor after an optional start request
  logic [15:0] cx_w, cy_w;
  assign cx_w = in_w.start_req ? in_w.start_x : cursor_x_q;
  assign cy_w = in_w.start_req ? in_w.start_y : cursor_y_q;

  // Read pipeline: s1 is the memory output, s2 the output register
  logic        s1_v_q, s1_last_q;
  logic [31:0] s1_addr_q;
  logic [7:0]  rd_data_q;
  logic        m_v_q, m_last_q;
  logic [31:0] m_addr_q;
  logic [7:0]  m_bits_q;

  logic s1_adv, issue, last_row;
  assign s1_adv   = s1_v_q && (!m_v_q || m_axis_tready);
  assign issue    = (state_q == bftr_pkg::ST_ROWS) && (!s1_v_q || s1_adv);
  assign last_row = (row_cnt_q == rows_q - RW'(1));

  assign s_axis_tready = (state_q == bftr_pkg::ST_IDLE);

  // Row count saturated to the maximum
  logic [6:0] rows_full;
  assign rows_full = ({1'b0, glyph_height_q} > 7'(MAX_GLYPH_ROWS)) ?
                     7'(MAX_GLYPH_ROWS) : {1'b0, glyph_height_q};

  logic [3:0] gw;
  assign gw = (glyph_width_q > bftr_pkg::MaxWidth) ? bftr_pkg::MaxWidth : glyph_width_q;

  logic [17:0] font_sum;
  assign font_sum = 18'(header_bytes_q) + 18'(prod_g_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bftr_pkg::ST_IDLE: begin
        if (in_acc && (s_axis_tuser == bftr_pkg::KindChar) &&
            (in_w.ch != bftr_pkg::ChCr) && (in_w.ch != bftr_pkg::ChLf)) begin
          state_d = bftr_pkg::ST_MUL;
        end
      end
      bftr_pkg::ST_MUL:  state_d = bftr_pkg::ST_ADDR;
      bftr_pkg::ST_ADDR: state_d = (rows_full == 7'd0) ? bftr_pkg::ST_IDLE
                                                      : bftr_pkg::ST_ROWS;
      bftr_pkg::ST_ROWS: begin
        if (issue && last_row) begin
          state_d = bftr_pkg::ST_IDLE;
        end
      end
      default: state_d = bftr_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= bftr_pkg::ST_IDLE;
      cursor_x_q <= 16'd0;
      cursor_y_q <= 16'd0;
      row_cnt_q  <= '0;
      s1_v_q     <= 1'b0;
      m_v_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      // cursor moves
      if (in_acc && (s_axis_tuser == bftr_pkg::KindChar)) begin
        if (in_w.ch == bftr_pkg::ChCr) begin
          cursor_x_q <= 16'd0;
          cursor_y_q <= cy_w;
        end else if (in_w.ch == bftr_pkg::ChLf) begin
          cursor_x_q <= 16'd0;
          cursor_y_q <= cy_w + 16'(glyph_height_q);
        end else begin
          cursor_x_q <= cx_w;
          cursor_y_q <= cy_w;
        end
      end else if (state_q == bftr_pkg::ST_ADDR) begin
        cursor_x_q <= cursor_x_q + 16'(gw) + 16'd1;
      end
      // row counter
      if (state_q == bftr_pkg::ST_ADDR) begin
        row_cnt_q <= '0;
      end else if (issue) begin
        row_cnt_q <= row_cnt_q + RW'(1);
      end
      // pipeline valids
      if (issue) begin
        s1_v_q <= 1'b1;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      if (s1_adv) begin
        m_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_v_q <= 1'b0;
      end
    end
  end

  // Address setup: products, then sums
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      gidx_q <= ({2'b00, in_w.ch} < glyph_count_q) ? in_w.ch : 8'd0;
    end
    if (state_q == bftr_pkg::ST_MUL) begin
      prod_y_q <= 32'(cursor_y_q) * 32'(line_pitch_q);
      prod_g_q <= 17'(gidx_q) * 17'(glyph_bytes_q);
    end
    if (state_q == bftr_pkg::ST_ADDR) begin
      row_addr_q <= frame_base_q + prod_y_q + 32'({cursor_x_q, 2'b00});
      ptr_q      <= font_sum[AW-1:0];
      rows_q     <= rows_full[RW-1:0];
    end else if (issue) begin
      row_addr_q <= row_addr_q + 32'(line_pitch_q);
      ptr_q      <= ptr_q + AW'(1);
    end
    if (issue) begin
      s1_addr_q <= row_addr_q;
      s1_last_q <= last_row;
    end
    if (s1_adv) begin
      m_addr_q <= s1_addr_q;
      m_last_q <= s1_last_q;
      m_bits_q <= rd_data_q;
    end
  end

  // Font store: loads only while idle, reads only while drawing rows,
  // so a write and a read never meet in one cycle
  logic [7:0] font_mem [FONT_BYTES];

  always_ff @(posedge clk_i) begin
    if (in_acc && (s_axis_tuser == bftr_pkg::KindLoad)) begin
      font_mem[load_addr_ext[AW-1:0]] <= in_w.font_byte;
    end
    if (issue) begin
      rd_data_q <= font_mem[ptr_q];
    end
  end

  // Output word
  bftr_pkg::out_data_t out_w;
  assign out_w.row_address = m_addr_q;
  assign out_w.row_bits    = m_bits_q;

  assign m_axis_tvalid = m_v_q;
  assign m_axis_tdata  = out_w;
  assign m_axis_tlast  = m_last_q;

endmodule

/* hdl/bftr_checker.sv */
`include "assert_macros.svh"

module bftr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [63:0] s_axis_tdata,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  logic s_acc, drawn;
  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign drawn = s_acc && s_axis_tuser &&
                 (s_axis_tdata[28:21] != bftr_pkg::ChCr) &&
                 (s_axis_tdata[28:21] != bftr_pkg::ChLf);

  // a stalled output word holds
  `ASSERT_CLK(out_hold_a, m_axis_tvalid && !m_axis_tready |=>
              m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
              "output word changed while stalled")

  // a drawn glyph occupies the sequencer for the address setup
  `ASSERT_CLK(draw_busy_a, drawn |=> !s_axis_tready,
              "input taken during glyph setup")

  // loads finish in the cycle they are taken
  `ASSERT_CLK(load_ready_a, s_acc && !s_axis_tuser |=> s_axis_tready,
              "input stalled after a font load")

endmodule

bind bitmap_font_text_renderer bftr_checker u_bftr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
